// ===== rtl/sva_pkg.sv =====
// Shared types, constants and helpers for the voice allocator.
`timescale 1ns / 1ps
package sva_pkg;

    localparam int VOICES   = 8;
    localparam int VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W    = $clog2(VOICES + 1);
    localparam int MASK_N   = (VOICES < 8) ? VOICES : 8;
    localparam int CLK_W    = 32;
    localparam int RLEN_W   = 20;
    localparam int NOTE_W   = 7;
    localparam int TYPE_W   = 2;
    localparam int KIND_W   = 2;

    localparam logic [RLEN_W-1:0] RLEN_RESET = RLEN_W'(28800);

    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIT     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // scan record handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [VIDX_W-1:0] pick;
        logic [CLK_W-1:0]  pick_time;
        logic [CNT_W-1:0]  count;
    } carry_t;

    // current request, seen by every cell
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NOTE_W-1:0] note;
        logic [TYPE_W-1:0] hit_type;
        logic [CLK_W-1:0]  clock;
        logic [RLEN_W-1:0] rel_len;
    } cell_req_t;

    // voice load at the end of a hit
    typedef struct packed {
        logic              en;
        logic [VIDX_W-1:0] pick;
        logic [NOTE_W-1:0] note;
        logic [TYPE_W-1:0] hit_type;
        logic [CLK_W-1:0]  clock;
    } wb_t;

    function automatic logic [3:0] sat_count(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'd15) ? 4'd15 : w[3:0];
    endfunction

endpackage

// ===== rtl/sva_cell.sv =====
// One voice slot: holds the voice state and passes the scan record on.
`timescale 1ns / 1ps
module sva_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sva_pkg::VIDX_W-1:0]  cell_idx,
    input  sva_pkg::cell_req_t          req,
    input  logic                        valid_in,
    input  sva_pkg::carry_t             carry_in,
    input  sva_pkg::wb_t                wb,
    output logic                        valid_out,
    output sva_pkg::carry_t             carry_out,
    output logic                        active
);

    logic                         active_reg, active_next;
    logic                         released_reg, released_next;
    logic [sva_pkg::NOTE_W-1:0]   note_reg, note_next;
    logic [sva_pkg::TYPE_W-1:0]   type_reg, type_next;
    logic [sva_pkg::CLK_W-1:0]    hit_time_reg, hit_time_next;
    logic [sva_pkg::CLK_W-1:0]    rel_time_reg, rel_time_next;
    logic                         valid_reg;
    sva_pkg::carry_t              carry_reg, carry_next;

    logic                         match;
    logic [sva_pkg::CLK_W-1:0]    age;

    assign match = active_reg && (note_reg == req.note) && (type_reg == req.hit_type);
    assign age   = req.clock - rel_time_reg;

    always_comb
    begin
        active_next   = active_reg;
        released_next = released_reg;
        note_next     = note_reg;
        type_next     = type_reg;
        hit_time_next = hit_time_reg;
        rel_time_next = rel_time_reg;
        carry_next    = carry_in;
        if (valid_in)
        begin
            case (req.kind)
                sva_pkg::KIND_HIT:
                begin
                    if (!carry_in.found)
                    begin
                        if (match || !active_reg)
                        begin
                            carry_next.found = 1'b1;
                            carry_next.pick  = cell_idx;
                        end
                        else if (hit_time_reg <= carry_in.pick_time)
                        begin
                            // ties go to the later voice
                            carry_next.pick      = cell_idx;
                            carry_next.pick_time = hit_time_reg;
                        end
                    end
                end
                sva_pkg::KIND_RELEASE:
                begin
                    if (match)
                    begin
                        released_next    = 1'b1;
                        rel_time_next    = req.clock;
                        carry_next.count = carry_in.count + 1'b1;
                    end
                end
                sva_pkg::KIND_TICK:
                begin
                    if (active_reg && released_reg &&
                        age >= sva_pkg::CLK_W'(req.rel_len))
                    begin
                        active_next      = 1'b0;
                        released_next    = 1'b0;
                        hit_time_next    = '1;
                        rel_time_next    = '1;
                        carry_next.count = carry_in.count + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (wb.en && wb.pick == cell_idx)
        begin
            active_next   = 1'b1;
            released_next = 1'b0;
            note_next     = wb.note;
            type_next     = wb.hit_type;
            hit_time_next = wb.clock;
            rel_time_next = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            released_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            released_reg <= released_next;
            valid_reg    <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg     <= note_next;
        type_reg     <= type_next;
        hit_time_reg <= hit_time_next;
        rel_time_reg <= rel_time_next;
        carry_reg    <= carry_next;
    end

    assign valid_out = valid_reg;
    assign carry_out = carry_reg;
    assign active    = active_reg;

endmodule

// ===== rtl/synth_voice_allocator.sv =====
// Top level of the voice allocator: request handling, sample clock, result register.
//
// Input requests arrive on s_tvalid/s_tready/s_tdata: a sample tick, a note hit
// or a note release. Each request produces exactly one result on
// m_tvalid/m_tready/m_tdata. release_length is loaded through cfg_we/cfg_wdata;
// load it only while no request is in flight (the block does not enforce this).
// A request walks the chain of voice cells, one cell per cycle, then the finish
// state loads the chosen voice on a hit and fills the result register. The
// block takes no new request until the current one has left the finish state,
// since s_tready is high only in the idle state.
// A finished result waits in the output register while the next request is
// accepted and scanned; if the receiver still stalls, that request holds in the
// finish state until the register frees up, and s_tready stays low meanwhile.
// Reset clears all voices, the sample clock and the output valid, and loads
// release_length with 28800. No clearing pass is needed.
`timescale 1ns / 1ps
module synth_voice_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // kind[1:0], note[8:2], hit_type[10:9], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // voice[2:0], stolen[3], released_count[7:4],
                                    // active_mask[15:8]
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata   // release_length
);

    localparam int N = sva_pkg::VOICES;

    sva_pkg::state_t                state_reg, state_next;
    logic                           start_reg;
    logic [sva_pkg::KIND_W-1:0]     kind_reg;
    logic [sva_pkg::NOTE_W-1:0]     note_reg;
    logic [sva_pkg::TYPE_W-1:0]     type_reg;
    logic [sva_pkg::CLK_W-1:0]      clock_reg;
    logic [sva_pkg::RLEN_W-1:0]     rel_len_reg;
    sva_pkg::carry_t                fin_reg;
    logic                           out_valid_reg;
    logic [15:0]                    out_data_reg, out_data_next;

    logic                           accept;
    logic                           fire;
    logic                           is_hit;
    sva_pkg::cell_req_t             req;
    sva_pkg::wb_t                   wb;
    sva_pkg::carry_t                init_carry;
    sva_pkg::carry_t                co [N];
    logic [N-1:0]                   cv;
    logic [N-1:0]                   act;
    logic [N-1:0]                   act_after;
    logic [7:0]                     mask;
    logic [31:0]                    pick_w;

    assign accept = s_tvalid && s_tready;
    assign is_hit = (kind_reg == sva_pkg::KIND_HIT);

    assign req.kind     = kind_reg;
    assign req.note     = note_reg;
    assign req.hit_type = type_reg;
    assign req.clock    = clock_reg;
    assign req.rel_len  = rel_len_reg;

    assign init_carry.found     = 1'b0;
    assign init_carry.pick      = '0;
    assign init_carry.pick_time = '1;
    assign init_carry.count     = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                sva_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .cell_idx  (sva_pkg::VIDX_W'(g)),
                    .req       (req),
                    .valid_in  (start_reg),
                    .carry_in  (init_carry),
                    .wb        (wb),
                    .valid_out (cv[g]),
                    .carry_out (co[g]),
                    .active    (act[g])
                );
            end
            else
            begin : g_next
                sva_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .cell_idx  (sva_pkg::VIDX_W'(g)),
                    .req       (req),
                    .valid_in  (cv[g-1]),
                    .carry_in  (co[g-1]),
                    .wb        (wb),
                    .valid_out (cv[g]),
                    .carry_out (co[g]),
                    .active    (act[g])
                );
            end
            assign act_after[g] = act[g] ||
                (is_hit && fin_reg.pick == sva_pkg::VIDX_W'(g));
        end
        for (g = 0; g < 8; g++)
        begin : g_mask
            if (g < sva_pkg::MASK_N)
            begin : g_on
                assign mask[g] = act_after[g];
            end
            else
            begin : g_off
                assign mask[g] = 1'b0;
            end
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sva_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = sva_pkg::ST_SCAN;
            end
            sva_pkg::ST_SCAN:
            begin
                if (cv[N-1])
                    state_next = sva_pkg::ST_FINISH;
            end
            sva_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = sva_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sva_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        fire     = 1'b0;
        case (state_reg)
            sva_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            sva_pkg::ST_FINISH:
            begin
                fire = !out_valid_reg || m_tready;
            end
            default:
            begin
            end
        endcase
    end

    assign wb.en       = fire && is_hit;
    assign wb.pick     = fin_reg.pick;
    assign wb.note     = note_reg;
    assign wb.hit_type = type_reg;
    assign wb.clock    = clock_reg;

    assign pick_w = 32'(fin_reg.pick);

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[2:0]   = is_hit ? pick_w[2:0] : 3'd0;
        out_data_next[3]     = is_hit && !fin_reg.found;
        out_data_next[7:4]   = sva_pkg::sat_count(fin_reg.count);
        out_data_next[15:8]  = mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sva_pkg::ST_IDLE;
            start_reg     <= 1'b0;
            clock_reg     <= '0;
            rel_len_reg   <= sva_pkg::RLEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (cfg_we)
                rel_len_reg <= cfg_wdata;
            if (fire && kind_reg == sva_pkg::KIND_TICK)
                clock_reg <= clock_reg + 1'b1;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tdata[1:0];
            note_reg <= s_tdata[8:2];
            type_reg <= s_tdata[10:9];
        end
        if (state_reg == sva_pkg::ST_SCAN && cv[N-1])
            fin_reg <= co[N-1];
        if (fire)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // the scan record sits in at most one cell at a time
    a_one_cell: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cv))
        else $error("scan record in more than one cell");

    // the end of the chain is reached only while scanning
    a_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cv[N-1] |-> state_reg == sva_pkg::ST_SCAN)
        else $error("chain end reached outside scan");

    // an accepted request enters the first cell next cycle
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> start_reg && state_reg == sva_pkg::ST_SCAN)
        else $error("request did not enter the chain");

    // a steal only happens with every voice busy
    a_steal_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sva_pkg::ST_FINISH && is_hit && !fin_reg.found) |-> &act)
        else $error("steal with a free voice");
`endif

endmodule
